// ===== sv/lcgrr_pkg.sv =====
// Shared types and constants for the LCG range generator.
// Used by lcgrr_ctrl, lcgrr_dp and lcg_random_range_generator; no dependencies.
package lcgrr_pkg;

  // Generator recurrence: seed * LCG_MUL + LCG_ADD, modulo 2^32
  localparam int unsigned SEED_W   = 32;
  localparam logic [17:0] LCG_MUL  = 18'd214013;
  localparam logic [31:0] LCG_ADD  = 32'd2531011;
  localparam int unsigned MIX_SHIFT  = 15;
  localparam int unsigned FRAC_SHIFT = 16;

  // Scaled-mode divisor is 2^16 - 1
  localparam logic [17:0] FRAC_DIV = 18'd65535;

  // Restoring divider: one quotient bit per cycle over a 32-bit dividend
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_PREP,
    ST_DIV,
    ST_SCALE,
    ST_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic adv_seed;
    logic prep;
    logic div_step;
    logic scale;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic func;
    logic err;
    logic div_last;
  } stat_t;

endpackage

// ===== sv/lcg_random_range_generator.sv =====
// LCG random range generator, top level: lcgrr_ctrl sequences lcgrr_dp.
// Integer mode: accept, seed advance, operand prep, the one-bit-per-cycle restoring divider,
// then result load; scaled mode has one scale step in place of the divider; an inverted range skips both.
// One item in flight at a time; a finished result waits in the output register.
// Reset (rst_n, synchronous, active low) clears the running seed and the control state.
module lcg_random_range_generator import lcgrr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic signed [31:0] in_low_bound,
  input  logic signed [31:0] in_high_bound,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic               out_range_error
);

  cmd_t  cmd;
  stat_t stat;

  lcgrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lcgrr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_func         (in_func),
    .in_low_bound    (in_low_bound),
    .in_high_bound   (in_high_bound),
    .cmd             (cmd),
    .stat            (stat),
    .out_value       (out_value),
    .out_range_error (out_range_error)
  );

  // Never overwrite a result that has not been transferred
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten before transfer");

  // One item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // Divider stops after its last step
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && stat.div_last) |=> !cmd.div_step)
    else $error("divider stepped past its last bit");

  // A loaded result is presented valid on the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

endmodule

// ===== sv/lcgrr_ctrl.sv =====
// Controller state machine for the LCG range generator.
// Depends on lcgrr_pkg; drives cmd_t to lcgrr_dp and owns the handshake flags.
module lcgrr_ctrl import lcgrr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Result slot can take a new result when empty or being drained
  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SEED;
      end
      ST_SEED: state_nxt = ST_PREP;
      ST_PREP: begin
        if (stat.err)       state_nxt = ST_OUT;
        else if (stat.func) state_nxt = ST_SCALE;
        else                state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_last) state_nxt = ST_OUT;
      end
      ST_SCALE: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_SEED:  cmd.adv_seed = 1'b1;
      ST_PREP:  cmd.prep     = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_SCALE: cmd.scale    = 1'b1;
      ST_OUT:   cmd.load_out = out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  // Hold result valid until transfer, set on a new load
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out)             out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/lcgrr_dp.sv =====
// Datapath for the LCG range generator: seed, operands, divider, result register.
// Depends on lcgrr_pkg; sequenced by cmd_t from lcgrr_ctrl.
module lcgrr_dp import lcgrr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_func,
  input  logic signed [31:0] in_low_bound,
  input  logic signed [31:0] in_high_bound,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic signed [31:0] out_value,
  output logic               out_range_error
);

  logic [SEED_W-1:0] seed_r, seed_nxt;
  logic              func_r;
  logic [31:0]       lo_r, hi_r;
  logic              err_r;
  logic [47:0]       acc_r, acc_nxt;   // dividend shifter or scaled product
  logic [32:0]       div_r;            // span, up to 2^32
  logic [31:0]       rem_r, rem_nxt;   // remainder, later the scaled quotient
  logic [CNT_W-1:0]  cnt_r;
  logic [31:0]       out_value_r;
  logic              out_err_r;

  logic [49:0]       seed_prod;
  logic [32:0]       diff;
  logic [31:0]       mixed;
  logic [15:0]       frac;
  logic [32:0]       rem_sh;
  logic [15:0]       sa, sb, sc;
  logic [17:0]       ssum;
  logic [1:0]        kfix;
  logic [32:0]       quot;
  logic [31:0]       sum_res;

  // Advance the generator
  assign seed_prod = seed_r * LCG_MUL;
  assign seed_nxt  = seed_prod[31:0] + LCG_ADD;

  // Span of the range in 33 bits; negative means inverted bounds
  assign diff  = {hi_r[31], hi_r} - {lo_r[31], lo_r};
  assign mixed = seed_r ^ (seed_r >> MIX_SHIFT);
  assign frac  = seed_r[SEED_W-1:FRAC_SHIFT];

  // One restoring-division step
  assign rem_sh = {rem_r, acc_r[31]};
  always_comb begin
    acc_nxt = {acc_r[46:0], 1'b0};
    if (rem_sh >= div_r) rem_nxt = 32'(rem_sh - div_r);
    else                 rem_nxt = rem_sh[31:0];
  end

  // Divide by 2^16-1: x = a*2^32 + b*2^16 + c gives q = a*65537 + b + (a+b+c)/65535
  assign sa   = acc_r[47:32];
  assign sb   = acc_r[31:16];
  assign sc   = acc_r[15:0];
  assign ssum = 18'(sa) + 18'(sb) + 18'(sc);
  always_comb begin
    if (ssum >= 18'(3 * FRAC_DIV))      kfix = 2'd3;
    else if (ssum >= 18'(2 * FRAC_DIV)) kfix = 2'd2;
    else if (ssum >= FRAC_DIV)          kfix = 2'd1;
    else                                kfix = 2'd0;
  end
  assign quot = {1'b0, sa, 16'b0} + 33'(sa) + 33'(sb) + 33'(kfix);

  // Final offset from the low bound
  assign sum_res = lo_r + rem_r;

  // Seed register: config write reloads, each item advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end else if (cmd.adv_seed) begin
      seed_r <= seed_nxt;
    end
  end

  // Operand, divider and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= in_func;
      lo_r   <= in_low_bound;
      hi_r   <= in_high_bound;
    end
    if (cmd.prep) begin
      err_r <= diff[32];
      rem_r <= '0;
      cnt_r <= '0;
      div_r <= diff + 33'd1;
      if (func_r) acc_r <= 48'(diff[31:0] * frac);
      else        acc_r <= {16'b0, mixed};
    end
    if (cmd.div_step) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.scale) begin
      rem_r <= quot[31:0];
    end
    if (cmd.load_out) begin
      out_value_r <= err_r ? lo_r : sum_res;
      out_err_r   <= err_r;
    end
  end

  assign stat.func     = func_r;
  assign stat.err      = diff[32];
  assign stat.div_last = (cnt_r == CNT_W'(DIV_STEPS - 1));

  assign out_value       = out_value_r;
  assign out_range_error = out_err_r;

endmodule
